### sv/lprl_pkg.sv
package lprl_pkg;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int CFG_W   = 9;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 4;
  localparam int INDEX_W = 8;

  // controller -> datapath
  typedef struct packed {
    logic wr_entry;  // store the route fields of the accepted item
    logic lookup;    // latch destination and count, clear best match
    logic issue;     // read the table slot under the scan counter
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;  // no slots in use
    logic last;        // scan counter is on the final slot
  } stat_t;

endpackage

### sv/lprl_ctrl.sv
module lprl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cmd,
  input  lprl_pkg::stat_t stat,
  output lprl_pkg::ctrl_t ctrl,
  output logic            busy,
  output logic            done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next    = state;
    done_next     = 1'b0;
    ctrl.wr_entry = accept && (cmd == lprl_pkg::CMD_WRITE);
    ctrl.lookup   = accept && (cmd == lprl_pkg::CMD_LOOKUP);
    ctrl.issue    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (ctrl.lookup) begin
          if (stat.count_zero) begin
            done_next = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.issue = 1'b1;
        if (stat.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared at the end of this cycle
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

### sv/lprl_dp.sv
module lprl_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lprl_pkg::ctrl_t                  ctrl,
  output lprl_pkg::stat_t                  stat,
  input  logic                             cfg_wr,
  input  logic [lprl_pkg::CFG_W-1:0]       cfg_data,
  input  logic [lprl_pkg::INDEX_W-1:0]     entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_prefix,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_mask,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0]      route_port,
  input  logic [lprl_pkg::ADDR_W-1:0]      dest_addr,
  output logic                             found,
  output logic [lprl_pkg::ADDR_W-1:0]      hop_addr,
  output logic [lprl_pkg::PORT_W-1:0]      out_port,
  output logic [lprl_pkg::INDEX_W-1:0]     match_index
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  typedef struct packed {
    logic [lprl_pkg::ADDR_W-1:0] prefix;
    logic [lprl_pkg::ADDR_W-1:0] mask;
    logic [lprl_pkg::ADDR_W-1:0] hop;
    logic [lprl_pkg::PORT_W-1:0] port;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  logic [lprl_pkg::CFG_W-1:0]  entry_count;
  logic [CNT_W-1:0]            limit;
  logic [CNT_W-1:0]            limit_next;
  logic [CNT_W-1:0]            scan_cnt;
  logic [lprl_pkg::ADDR_W-1:0] dest;
  entry_t                      rd_data;
  logic                        rd_vld;
  logic [IDX_W-1:0]            rd_idx;
  logic                        hit;
  logic [lprl_pkg::ADDR_W-1:0] best_mask;
  logic [IDX_W-1:0]            best_idx;

  logic [31:0]                 count32;
  logic [31:0]                 widx32;
  logic [31:0]                 bidx32;
  logic                        wr_ok;
  logic                        match;
  logic                        better;

  assign count32 = 32'(entry_count);
  assign widx32  = 32'(entry_index);
  assign bidx32  = 32'(best_idx);
  assign wr_ok   = (widx32 < DEPTH32);

  // counts above the table depth saturate
  always_comb begin
    if (count32 > DEPTH32) begin
      limit_next = DEPTH32[CNT_W-1:0];
    end else begin
      limit_next = count32[CNT_W-1:0];
    end
  end

  assign stat.count_zero = (entry_count == '0);
  assign stat.last       = ((scan_cnt + CNT_W'(1)) == limit);

  assign match  = ((dest & rd_data.mask) == (rd_data.prefix & rd_data.mask));
  assign better = match && (!hit || (rd_data.mask > best_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_entry && wr_ok) begin
      mem[widx32[IDX_W-1:0]] <= '{prefix: route_prefix, mask: route_mask,
                                  hop: route_next_hop, port: route_port};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      dest      <= dest_addr;
      limit     <= limit_next;
      scan_cnt  <= '0;
      hit       <= 1'b0;
      best_mask <= '0;
      best_idx  <= '0;
      hop_addr  <= '0;
      out_port  <= '0;
    end else begin
      if (ctrl.issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        rd_idx   <= scan_cnt[IDX_W-1:0];
      end
      if (rd_vld && better) begin
        hit       <= 1'b1;
        best_mask <= rd_data.mask;
        best_idx  <= rd_idx;
        hop_addr  <= rd_data.hop;
        out_port  <= rd_data.port;
      end
    end
  end

  assign found       = hit;
  assign match_index = bidx32[lprl_pkg::INDEX_W-1:0];

endmodule

### sv/longest_prefix_route_lookup.sv
// channel   ports                                              handshake
// -------   -----------------------------------------------   -------------------
// item in   cmd entry_index route_prefix route_mask            start & !busy
//           route_next_hop route_port dest_addr
// result    found hop_addr out_port match_index                done, one cycle
// config    cfg_data (entry_count)                             cfg_wr
//
// A write item gives no result; busy stays low.
// A lookup scans N = min(entry_count, TABLE_DEPTH) slots, one table read a cycle
// (the single table read port sets this rate): busy is high through the scan and
// a drain state, and done pulses in the first cycle busy is low; with N = 0 done
// pulses the cycle after the item is accepted. A new item may be taken in the cycle
// done is high. Synchronous reset clears entry_count and the controller; table
// contents are undefined until written. The receiver cannot stall results.
module longest_prefix_route_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [lprl_pkg::INDEX_W-1:0] entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]  route_prefix,
  input  logic [lprl_pkg::ADDR_W-1:0]  route_mask,
  input  logic [lprl_pkg::ADDR_W-1:0]  route_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0]  route_port,
  input  logic [lprl_pkg::ADDR_W-1:0]  dest_addr,
  output logic                         done,
  output logic                         found,
  output logic [lprl_pkg::ADDR_W-1:0]  hop_addr,
  output logic [lprl_pkg::PORT_W-1:0]  out_port,
  output logic [lprl_pkg::INDEX_W-1:0] match_index,
  input  logic                         cfg_wr,
  input  logic [lprl_pkg::CFG_W-1:0]   cfg_data
);

  lprl_pkg::ctrl_t ctrl;
  lprl_pkg::stat_t stat;

  lprl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  lprl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .cfg_wr         (cfg_wr),
    .cfg_data       (cfg_data),
    .entry_index    (entry_index),
    .route_prefix   (route_prefix),
    .route_mask     (route_mask),
    .route_next_hop (route_next_hop),
    .route_port     (route_port),
    .dest_addr      (dest_addr),
    .found          (found),
    .hop_addr       (hop_addr),
    .out_port       (out_port),
    .match_index    (match_index)
  );

`ifndef NO_ASSERTIONS
  // a miss reports all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (hop_addr == '0 && out_port == '0 && match_index == '0))
    else $error("miss result carries nonzero fields");

  // a write item never starts a scan or a result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == lprl_pkg::CMD_WRITE) |=> (!busy && !done))
    else $error("write item started a scan or a result");

  // a result only follows a scan or an accepted lookup
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start && cmd == lprl_pkg::CMD_LOOKUP)))
    else $error("result without a lookup");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while scanning");
`endif

endmodule
